>>> hw/rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Slot encoding, the effect pattern ROM and the per-LED lane interface types.
// ----------------------------------------------------------------------------
package lps_pkg;

  typedef enum logic [1:0] {
    SLOT_PAIR,
    SLOT_END,
    SLOT_LAST,
    SLOT_LOOP
  } slot_kind_t;

  // dur is the duration in ticks for a pair and the back count for a loop
  typedef struct packed {
    slot_kind_t  kind;
    logic        level;
    logic [7:0]  dur;
  } slot_t;

  localparam logic [2:0] NumPatterns = 3'd5;
  localparam logic [2:0] NumSlots    = 3'd5;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_QUEUE = 1'b1;

  typedef struct packed {
    logic        tick;
    logic        push;
    logic [2:0]  code;
    logic        clr;
  } lane_op_t;

  typedef struct packed {
    logic level;
    logic busy;
  } lane_stat_t;

  function automatic slot_t rom_slot(logic [2:0] pat, logic [2:0] pos);
    logic [2:0] p;
    logic [2:0] q;
    slot_t      s;
    p = (pat >= NumPatterns) ? 3'd0 : pat;
    q = (pos >= NumSlots) ? NumSlots - 3'd1 : pos;
    s = '{SLOT_END, 1'b0, 8'd0};
    case ({p, q})
      6'o00: s = '{SLOT_PAIR, 1'b0, 8'd10};
      6'o10: s = '{SLOT_PAIR, 1'b1, 8'd10};
      6'o20: s = '{SLOT_PAIR, 1'b1, 8'd100};
      6'o21: s = '{SLOT_LAST, 1'b0, 8'd0};
      6'o30: s = '{SLOT_PAIR, 1'b1, 8'd10};
      6'o31: s = '{SLOT_PAIR, 1'b0, 8'd10};
      6'o32: s = '{SLOT_PAIR, 1'b1, 8'd10};
      6'o33: s = '{SLOT_PAIR, 1'b0, 8'd100};
      6'o34: s = '{SLOT_LOOP, 1'b0, 8'd4};
      6'o40: s = '{SLOT_PAIR, 1'b1, 8'd50};
      6'o41: s = '{SLOT_PAIR, 1'b0, 8'd50};
      6'o42: s = '{SLOT_PAIR, 1'b1, 8'd50};
      6'o43: s = '{SLOT_PAIR, 1'b0, 8'd200};
      6'o44: s = '{SLOT_LOOP, 1'b0, 8'd4};
      default: s = '{SLOT_END, 1'b0, 8'd0};
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/lps_lane.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer lane
// One LED: command FIFO, pattern position, tick countdown and busy flag.
// ----------------------------------------------------------------------------
module lps_lane
  import lps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  lane_op_t   op,
  output lane_stat_t stat_nxt
);

  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [2:0]    pat_r, pat_nxt;
  logic [2:0]    pos_r, pos_nxt;
  logic [7:0]    tmr_r, tmr_nxt;
  logic          run_r, run_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [HW-1:0] head_r, head_nxt;
  logic [2:0]    q_r [QUEUE_DEPTH];

  logic          wr_en;
  logic [HW-1:0] wr_idx;
  logic [2:0]    pop_code;
  logic [2:0]    pos_inc;
  slot_t         s_next;
  logic [7:0]    tmr_dec;
  logic [2:0]    tgt;
  logic [CW-1:0] f_eff;
  logic [HW-1:0] h_eff;
  logic [CW:0]   tail_sum;

  assign pop_code = q_r[head_r];
  assign pos_inc  = pos_r + 3'd1;
  assign s_next   = rom_slot(pat_r, pos_inc);
  assign tmr_dec  = (tmr_r != 8'd0) ? tmr_r - 8'd1 : 8'd0;

  always_comb begin
    pat_nxt  = pat_r;
    pos_nxt  = pos_r;
    tmr_nxt  = tmr_r;
    run_nxt  = run_r;
    fill_nxt = fill_r;
    head_nxt = head_r;
    wr_en    = 1'b0;
    tgt      = pos_inc;
    f_eff    = op.clr ? '0 : fill_r;
    h_eff    = op.clr ? '0 : head_r;
    tail_sum = (CW+1)'(h_eff) + (CW+1)'(f_eff);
    wr_idx   = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
               HW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
    if (en && op.tick) begin
      if (!run_r && fill_r != '0) begin
        // idle with work queued: load it, no countdown this tick
        head_nxt = (head_r == HW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
        fill_nxt = fill_r - 1'b1;
        run_nxt  = 1'b1;
        if (pop_code < NumPatterns) begin
          pat_nxt = pop_code;
          pos_nxt = 3'd0;
          tmr_nxt = rom_slot(pop_code, 3'd0).dur;
        end
      end else begin
        tmr_nxt = tmr_dec;
        if (tmr_dec == 8'd0) begin
          if (pos_inc >= NumSlots) begin
            run_nxt = 1'b0;
          end else begin
            case (s_next.kind)
              SLOT_END: run_nxt = 1'b0;
              SLOT_LAST: begin
                pos_nxt = pos_inc;
                run_nxt = 1'b0;
              end
              default: begin
                if (s_next.kind == SLOT_LOOP) begin
                  tgt = (s_next.dur <= {5'd0, pos_inc}) ? pos_inc - s_next.dur[2:0] : 3'd0;
                end
                pos_nxt = tgt;
                tmr_nxt = rom_slot(pat_r, tgt).dur;
              end
            endcase
          end
        end
      end
    end else if (en && op.push) begin
      if (op.clr) begin
        run_nxt  = 1'b0;
        fill_nxt = '0;
        head_nxt = '0;
      end
      // full queue drops the command
      if (f_eff < CW'(QUEUE_DEPTH)) begin
        wr_en    = 1'b1;
        fill_nxt = f_eff + 1'b1;
      end
    end
  end

  always_comb begin
    stat_nxt.level = rom_slot(pat_nxt, pos_nxt).level;
    stat_nxt.busy  = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= 3'd0;
      pos_r  <= 3'd0;
      tmr_r  <= 8'd10;
      run_r  <= 1'b0;
      fill_r <= '0;
      head_r <= '0;
    end else begin
      pat_r  <= pat_nxt;
      pos_r  <= pos_nxt;
      tmr_r  <= tmr_nxt;
      run_r  <= run_nxt;
      fill_r <= fill_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_idx] <= op.code;
    end
  end

endmodule

>>> hw/rtl/led_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer
// Per-LED effect queues feeding pattern players; one status beat per item.
// ----------------------------------------------------------------------------
//   Channel | Direction | Fields
//   in_     | input     | func, led_index, effect_code, clear_first
//   out_    | output    | led_levels, busy_flags
//
// An item is taken into the input register, then applied to all LED lanes as
// it advances, with the resulting levels and flags landing in the output
// register; one item per cycle sustained while out_stall is low.
// Reset clears all lanes to idle, off pattern, countdown 10, empty queues.
// in_stall rises only when both the input and output registers are full and
// out_stall is high.
// ----------------------------------------------------------------------------
module led_pattern_sequencer
  import lps_pkg::*;
#(
  parameter int NUM_LEDS    = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [1:0] in_led_index,
  input  logic [2:0] in_effect_code,
  input  logic       in_clear_first,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_led_levels,
  output logic [3:0] out_busy_flags
);

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_func_r;
  logic [1:0] s1_led_index_r;
  logic [2:0] s1_effect_code_r;
  logic       s1_clear_first_r;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] levels_r, busy_r;
  logic [3:0] levels_nxt, busy_nxt;
  logic       accept, adv;

  lane_stat_t stat [NUM_LEDS];

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_nxt  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
    lane_op_t op;
    always_comb begin
      op.tick = (s1_func_r == FUNC_TICK);
      op.push = (s1_func_r == FUNC_QUEUE) && (int'(s1_led_index_r) == i);
      op.code = s1_effect_code_r;
      op.clr  = s1_clear_first_r;
    end
    lps_lane #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .op       (op),
      .stat_nxt (stat[i])
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_bits
    if (i < NUM_LEDS) begin : g_on
      assign levels_nxt[i] = stat[i].level;
      assign busy_nxt[i]   = stat[i].busy;
    end else begin : g_off
      assign levels_nxt[i] = 1'b0;
      assign busy_nxt[i]   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r        <= in_func;
      s1_led_index_r   <= in_led_index;
      s1_effect_code_r <= in_effect_code;
      s1_clear_first_r <= in_clear_first;
    end
    if (adv) begin
      levels_r <= levels_nxt;
      busy_r   <= busy_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_levels = levels_r;
  assign out_busy_flags = busy_r;

endmodule

>>> hw/rtl/lps_checker.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_led_levels,
  input logic [3:0] out_busy_flags
);

  // input backpressure only comes from a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output beat");

  // nothing comes out in the cycle right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_valid)
    else $error("output beat right after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("output beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_led_levels) && $stable(out_busy_flags)))
    else $error("output payload changed under stall");

endmodule

bind led_pattern_sequencer lps_checker u_lps_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_led_levels (out_led_levels),
  .out_busy_flags (out_busy_flags)
);

>>> bench/lps_checker.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer checker
// Watches both channels. Keeps its own copy of the LED lanes: the effect
// queues, the pattern position and the slot timer. For every accepted input
// beat it works out the expected levels and busy flags. Every accepted result
// beat is compared in order against those expectations.
// ----------------------------------------------------------------------------
module lps_scoreboard
  import lps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_func,
  input  logic [1:0] in_led_index,
  input  logic [2:0] in_effect_code,
  input  logic       in_clear_first,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] out_led_levels,
  input  logic [3:0] out_busy_flags,
  output int         errors,
  output int         pending
);

  localparam int NLED   = 4;
  localparam int QDEPTH = 4;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [3:0] levels;
    logic [3:0] busy;
  } led_status_t;

  // Effect patterns, one row per effect code, padded with end marks
  localparam slot_t EFFECT_ROM [5][5] = '{
    '{'{SLOT_PAIR, 1'b0, 8'd10}, '{SLOT_END, 1'b0, 8'd0}, '{SLOT_END, 1'b0, 8'd0},
      '{SLOT_END, 1'b0, 8'd0}, '{SLOT_END, 1'b0, 8'd0}},
    '{'{SLOT_PAIR, 1'b1, 8'd10}, '{SLOT_END, 1'b0, 8'd0}, '{SLOT_END, 1'b0, 8'd0},
      '{SLOT_END, 1'b0, 8'd0}, '{SLOT_END, 1'b0, 8'd0}},
    '{'{SLOT_PAIR, 1'b1, 8'd100}, '{SLOT_LAST, 1'b0, 8'd0}, '{SLOT_END, 1'b0, 8'd0},
      '{SLOT_END, 1'b0, 8'd0}, '{SLOT_END, 1'b0, 8'd0}},
    '{'{SLOT_PAIR, 1'b1, 8'd10}, '{SLOT_PAIR, 1'b0, 8'd10}, '{SLOT_PAIR, 1'b1, 8'd10},
      '{SLOT_PAIR, 1'b0, 8'd100}, '{SLOT_LOOP, 1'b0, 8'd4}},
    '{'{SLOT_PAIR, 1'b1, 8'd50}, '{SLOT_PAIR, 1'b0, 8'd50}, '{SLOT_PAIR, 1'b1, 8'd50},
      '{SLOT_PAIR, 1'b0, 8'd200}, '{SLOT_LOOP, 1'b0, 8'd4}}
  };

  logic [2:0]  effect_fifo [NLED][QDEPTH];
  logic [2:0]  fifo_fill   [NLED];
  logic [1:0]  fifo_head   [NLED];
  logic [2:0]  cur_pattern [NLED];
  logic [2:0]  cur_slot    [NLED];
  logic [7:0]  slot_timer  [NLED];
  logic        lane_busy   [NLED];
  led_status_t status_q    [$];

  function automatic slot_t pattern_slot(logic [2:0] pat, logic [2:0] pos);
    logic [2:0] p;
    logic [2:0] q;
    p = (pat >= NumPatterns) ? 3'd0 : pat;
    q = (pos >= NumSlots) ? NumSlots - 3'd1 : pos;
    return EFFECT_ROM[p][q];
  endfunction

  function automatic void reset_lanes();
    for (int i = 0; i < NLED; i++) begin
      fifo_fill[i]   = '0;
      fifo_head[i]   = '0;
      cur_pattern[i] = '0;
      cur_slot[i]    = '0;
      slot_timer[i]  = 8'd10;
      lane_busy[i]   = 1'b0;
    end
  endfunction

  // Move one lane past a slot whose timer ran out
  function automatic void next_slot(int i);
    int    nxt;
    slot_t s;
    nxt = cur_slot[i] + 1;
    if (nxt >= NumSlots) begin
      lane_busy[i] = 1'b0;
      return;
    end
    s = pattern_slot(cur_pattern[i], 3'(nxt));
    case (s.kind)
      SLOT_END: lane_busy[i] = 1'b0;
      SLOT_LAST: begin
        cur_slot[i]  = 3'(nxt);
        lane_busy[i] = 1'b0;
      end
      default: begin
        if (s.kind == SLOT_LOOP) nxt = (s.dur <= nxt) ? nxt - int'(s.dur) : 0;
        cur_slot[i]   = 3'(nxt);
        slot_timer[i] = pattern_slot(cur_pattern[i], 3'(nxt)).dur;
      end
    endcase
  endfunction

  function automatic void tick_lanes();
    logic [2:0] code;
    for (int i = 0; i < NLED; i++) begin
      if (!lane_busy[i] && fifo_fill[i] != 0) begin
        // load the next effect; an unknown code keeps the old pattern
        code         = effect_fifo[i][fifo_head[i]];
        fifo_head[i] = fifo_head[i] + 2'd1;
        fifo_fill[i] = fifo_fill[i] - 3'd1;
        lane_busy[i] = 1'b1;
        if (code < NumPatterns) begin
          cur_pattern[i] = code;
          cur_slot[i]    = '0;
          slot_timer[i]  = pattern_slot(code, 3'd0).dur;
        end
      end else begin
        if (slot_timer[i] != 0) slot_timer[i] = slot_timer[i] - 8'd1;
        if (slot_timer[i] == 0) next_slot(i);
      end
    end
  endfunction

  function automatic void queue_effect(logic [1:0] led, logic [2:0] code, logic clr);
    logic [1:0] tail;
    if (clr) begin
      fifo_fill[led] = '0;
      fifo_head[led] = '0;
      lane_busy[led] = 1'b0;
    end
    // drop the command when the queue is full
    if (fifo_fill[led] >= QDEPTH) return;
    tail = fifo_head[led] + fifo_fill[led][1:0];
    effect_fifo[led][tail] = code;
    fifo_fill[led] = fifo_fill[led] + 3'd1;
  endfunction

  function automatic led_status_t lane_status();
    led_status_t st;
    for (int i = 0; i < NLED; i++) begin
      st.levels[i] = pattern_slot(cur_pattern[i], cur_slot[i]).level;
      st.busy[i]   = lane_busy[i];
    end
    return st;
  endfunction

  function automatic void flag_error(string msg);
    if (errors < MAX_REPORTS) $display("%s", msg);
    errors++;
  endfunction

  always @(posedge clk) begin
    led_status_t want;
    if (!rst_n) begin
      reset_lanes();
      status_q.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_TICK) tick_lanes();
        else queue_effect(in_led_index, in_effect_code, in_clear_first);
        status_q.push_back(lane_status());
      end
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          flag_error($sformatf("unexpected result beat: levels %b busy %b",
                               out_led_levels, out_busy_flags));
        end else begin
          want = status_q.pop_front();
          if (out_led_levels !== want.levels || out_busy_flags !== want.busy)
            flag_error($sformatf("mismatch: levels exp %b got %b, busy exp %b got %b",
                                 want.levels, out_led_levels, want.busy, out_busy_flags));
        end
      end
    end
    pending = status_q.size();
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer testbench
// Drives tick and effect command beats into the sequencer. A short directed
// run covers every effect code, the unknown codes, a full queue and clears.
// Random sessions follow: command bursts, then tick bursts long enough to
// reach pattern ends and loop-backs. Both sides idle under changing pressure.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import lps_pkg::*;

  localparam logic [2:0] EFFECT_OFF   = 3'd0;
  localparam logic [2:0] EFFECT_ON    = 3'd1;
  localparam logic [2:0] EFFECT_PULSE = 3'd2;
  localparam logic [2:0] EFFECT_FAST  = 3'd3;
  localparam logic [2:0] EFFECT_SLOW  = 3'd4;
  localparam logic [2:0] EFFECT_RSVD5 = 3'd5;
  localparam logic [2:0] EFFECT_RSVD6 = 3'd6;
  localparam logic [2:0] EFFECT_RSVD7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 300;
  localparam int TAIL_CYCLES    = 10;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_func        = 1'b0;
  logic [1:0] in_led_index   = '0;
  logic [2:0] in_effect_code = '0;
  logic       in_clear_first = 1'b0;
  logic       out_stall      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [3:0] out_led_levels;
  logic [3:0] out_busy_flags;
  int         errors;
  int         pending;
  int         idle_pct  = 0;
  int         stall_pct = 30;
  int         quiet_cycles = 0;

  always #2 clk = ~clk;

  led_pattern_sequencer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_led_index   (in_led_index),
    .in_effect_code (in_effect_code),
    .in_clear_first (in_clear_first),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_led_levels (out_led_levels),
    .out_busy_flags (out_busy_flags)
  );

  lps_scoreboard i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_led_index   (in_led_index),
    .in_effect_code (in_effect_code),
    .in_clear_first (in_clear_first),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_led_levels (out_led_levels),
    .out_busy_flags (out_busy_flags),
    .errors         (errors),
    .pending        (pending)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Present one beat and hold it until taken
  task automatic send_beat(input logic f, input logic [1:0] led, input logic [2:0] code,
                           input logic clr);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_led_index   <= led;
    in_effect_code <= code;
    in_clear_first <= clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_tick();
    send_beat(FUNC_TICK, 2'($urandom_range(3)), 3'($urandom_range(7)), 1'($urandom_range(1)));
  endtask

  task automatic send_command();
    logic [2:0] code;
    code = ($urandom_range(99) < 10) ? 3'($urandom_range(EFFECT_RSVD5, EFFECT_RSVD7))
                                     : 3'($urandom_range(EFFECT_OFF, EFFECT_SLOW));
    send_beat(FUNC_QUEUE, 2'($urandom_range(3)), code, $urandom_range(99) < 12);
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Command bursts followed by tick bursts, some long enough to loop back
  task automatic run_sessions(input int n_items);
    int sent;
    int ncmd;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      ncmd = $urandom_range(1, 5);
      for (int k = 0; k < ncmd; k++) begin
        send_command();
        sent++;
      end
      burst = ($urandom_range(99) < 15) ? $urandom_range(300, 420) : $urandom_range(5, 120);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        if ($urandom_range(99) < 4) send_command();
        else send_tick();
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_beat(FUNC_TICK, 2'd3, EFFECT_RSVD7, 1'b1);
    send_beat(FUNC_QUEUE, 2'd0, EFFECT_OFF, 1'b0);
    send_beat(FUNC_QUEUE, 2'd1, EFFECT_ON, 1'b0);
    send_beat(FUNC_QUEUE, 2'd2, EFFECT_PULSE, 1'b0);
    send_beat(FUNC_QUEUE, 2'd3, EFFECT_FAST, 1'b1);
    send_beat(FUNC_QUEUE, 2'd0, EFFECT_SLOW, 1'b0);
    send_beat(FUNC_QUEUE, 2'd1, EFFECT_RSVD5, 1'b0);
    send_beat(FUNC_QUEUE, 2'd1, EFFECT_RSVD6, 1'b0);
    send_beat(FUNC_QUEUE, 2'd1, EFFECT_RSVD7, 1'b0);
    // queue of LED 1 is full now, so this one drops
    send_beat(FUNC_QUEUE, 2'd1, EFFECT_SLOW, 1'b0);
    send_beat(FUNC_TICK, 2'd0, EFFECT_OFF, 1'b0);
    send_beat(FUNC_QUEUE, 2'd1, EFFECT_PULSE, 1'b1);
    send_beat(FUNC_TICK, 2'd1, EFFECT_ON, 1'b0);
    send_beat(FUNC_TICK, 2'd2, EFFECT_PULSE, 1'b1);
    send_beat(FUNC_QUEUE, 2'd3, EFFECT_SLOW, 1'b1);
    send_beat(FUNC_QUEUE, 2'd2, EFFECT_RSVD5, 1'b0);
    send_beat(FUNC_TICK, 2'd3, EFFECT_FAST, 1'b1);
    for (int i = 0; i < 6; i++) send_tick();
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct  = (ph == 0) ? 14 : (ph == 1) ? 75 : 0;
      stall_pct = (ph == 0) ? 75 : (ph == 1) ? 14 : 0;
      run_sessions(PHASE_ITEMS);
      drain_results();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
